// File: design/crc16_packet_checker_core_defines.svh
// ---------------------------------------------------------------------------
// CRC-16 packet checker assertion macros
// Shared assertion forms used by the checker attached to the core.
// ---------------------------------------------------------------------------
`ifndef CRC16_PACKET_CHECKER_CORE_DEFINES_SVH
`define CRC16_PACKET_CHECKER_CORE_DEFINES_SVH

// Assertion that is checked only outside reset.
`define CRC16PC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define CRC16PC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/crc16pc_pkg.sv
// ---------------------------------------------------------------------------
// CRC-16 packet checker package
// Request and result types, status codes, constants and the CRC byte update.
// ---------------------------------------------------------------------------
package crc16pc_pkg;

  localparam int MAX_PACKET_BYTES = 64;
  localparam int COUNT_W = 7;
  localparam int CFG_INDEX_W = 2;

  localparam logic [COUNT_W-1:0] MIN_PACKET_BYTES = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PACKET_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_PACKET_BYTES + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [COUNT_W-1:0] EXPECTED_LEN_ZERO_RESET = COUNT_W'(24);
  localparam logic [COUNT_W-1:0] EXPECTED_LEN_TWO_RESET = COUNT_W'(22);

  localparam logic [7:0] TYPE_ZERO = 8'd0;
  localparam logic [7:0] TYPE_TWO = 8'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EXPECTED_LEN_TYPE_ZERO = 2'd0,
    CFG_EXPECTED_LEN_TYPE_TWO  = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_TOO_SHORT    = 3'd1,
    STATUS_TOO_LONG     = 3'd2,
    STATUS_UNKNOWN_TYPE = 3'd3,
    STATUS_BELOW_LENGTH = 3'd4,
    STATUS_CRC_MISMATCH = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [2:0]         status_code;
    logic [7:0]         packet_type;
    logic [7:0]         seq_number;
    logic [15:0]        timestamp;
    logic [COUNT_W-1:0] packet_length;
    logic [15:0]        crc_computed;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/crc16_packet_checker_core.sv
// ---------------------------------------------------------------------------
// CRC-16 packet checker core
// Runs CRC-16/MODBUS over a byte stream, captures the header fields and
// reports one status per packet on its last byte.
// ---------------------------------------------------------------------------
// Throughput is one byte per cycle except while a last byte waits; the CRC byte
// update is unrolled; a result is valid the cycle after its last byte is accepted.
// A last byte waits only while the previous result is still held unaccepted.
// Reset is synchronous and clears the packet state and the result valid flag,
// and restores the length registers to 24 and 22.
module crc16_packet_checker_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     byte_valid,
  output logic                                     byte_ready,
  input  crc16pc_pkg::byte_req_t                   byte_data,
  output logic                                     status_valid,
  input  logic                                     status_ready,
  output crc16pc_pkg::result_t                     status_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [crc16pc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [crc16pc_pkg::COUNT_W-1:0]          cfg_data
);

  logic [crc16pc_pkg::COUNT_W-1:0] expected_len_zero;
  logic [crc16pc_pkg::COUNT_W-1:0] expected_len_two;

  logic [15:0]                     crc_accum;
  logic [15:0]                     crc_accum_next;
  logic [crc16pc_pkg::COUNT_W-1:0] byte_count;
  logic [crc16pc_pkg::COUNT_W-1:0] byte_count_next;
  logic [7:0]                      delay_lo;
  logic [7:0]                      delay_hi;
  logic [7:0]                      type_hold;
  logic [7:0]                      type_hold_next;
  logic [7:0]                      seq_hold;
  logic [7:0]                      seq_hold_next;
  logic [15:0]                     time_hold;
  logic [15:0]                     time_hold_next;

  logic                            byte_accept;
  logic [15:0]                     crc_received;
  logic [crc16pc_pkg::COUNT_W-1:0] expected_len;
  crc16pc_pkg::status_t            status_next;
  crc16pc_pkg::result_t            result_next;

  assign cfg_ready = 1'b1;
  assign byte_ready = !status_valid || status_ready || !byte_data.last_byte;
  assign byte_accept = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len_zero <= crc16pc_pkg::EXPECTED_LEN_ZERO_RESET;
      expected_len_two <= crc16pc_pkg::EXPECTED_LEN_TWO_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        crc16pc_pkg::CFG_EXPECTED_LEN_TYPE_ZERO: expected_len_zero <= cfg_data;
        crc16pc_pkg::CFG_EXPECTED_LEN_TYPE_TWO:  expected_len_two <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    type_hold_next = type_hold;
    seq_hold_next = seq_hold;
    time_hold_next = time_hold;
    case (byte_count)
      crc16pc_pkg::COUNT_W'(0): type_hold_next = byte_data.rx_byte;
      crc16pc_pkg::COUNT_W'(1): seq_hold_next = byte_data.rx_byte;
      crc16pc_pkg::COUNT_W'(2): time_hold_next = {time_hold[15:8], byte_data.rx_byte};
      crc16pc_pkg::COUNT_W'(3): time_hold_next = {byte_data.rx_byte, time_hold[7:0]};
      default: begin
      end
    endcase

    if (byte_count >= crc16pc_pkg::COUNT_W'(2)) begin
      crc_accum_next = crc16pc_pkg::crc_byte(crc_accum, delay_lo);
    end else begin
      crc_accum_next = crc_accum;
    end

    if (byte_count < crc16pc_pkg::COUNT_LIMIT) begin
      byte_count_next = byte_count + crc16pc_pkg::COUNT_W'(1);
    end else begin
      byte_count_next = byte_count;
    end

    crc_received = {byte_data.rx_byte, delay_hi};
    expected_len = (type_hold_next == crc16pc_pkg::TYPE_ZERO) ? expected_len_zero
                                                              : expected_len_two;

    if (byte_count_next < crc16pc_pkg::MIN_PACKET_BYTES) begin
      status_next = crc16pc_pkg::STATUS_TOO_SHORT;
    end else if (byte_count_next > crc16pc_pkg::MAX_COUNT) begin
      status_next = crc16pc_pkg::STATUS_TOO_LONG;
    end else if (type_hold_next != crc16pc_pkg::TYPE_ZERO &&
                 type_hold_next != crc16pc_pkg::TYPE_TWO) begin
      status_next = crc16pc_pkg::STATUS_UNKNOWN_TYPE;
    end else if (byte_count_next < expected_len) begin
      status_next = crc16pc_pkg::STATUS_BELOW_LENGTH;
    end else if (crc_received != crc_accum_next) begin
      status_next = crc16pc_pkg::STATUS_CRC_MISMATCH;
    end else begin
      status_next = crc16pc_pkg::STATUS_OK;
    end

    result_next.status_code = status_next;
    result_next.packet_type = type_hold_next;
    result_next.seq_number = seq_hold_next;
    result_next.timestamp = time_hold_next;
    result_next.packet_length = byte_count_next;
    result_next.crc_computed = crc_accum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum <= crc16pc_pkg::CRC_INIT;
      byte_count <= '0;
      delay_lo <= '0;
      delay_hi <= '0;
      type_hold <= '0;
      seq_hold <= '0;
      time_hold <= '0;
    end else if (byte_accept) begin
      if (byte_data.last_byte) begin
        crc_accum <= crc16pc_pkg::CRC_INIT;
        byte_count <= '0;
        delay_lo <= '0;
        delay_hi <= '0;
        type_hold <= '0;
        seq_hold <= '0;
        time_hold <= '0;
      end else begin
        crc_accum <= crc_accum_next;
        byte_count <= byte_count_next;
        delay_lo <= delay_hi;
        delay_hi <= byte_data.rx_byte;
        type_hold <= type_hold_next;
        seq_hold <= seq_hold_next;
        time_hold <= time_hold_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (byte_accept && byte_data.last_byte) begin
      status_valid <= 1'b1;
    end else if (status_ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept && byte_data.last_byte) begin
      status_data <= result_next;
    end
  end

endmodule

// File: design/crc16pc_checker.sv
// ---------------------------------------------------------------------------
// CRC-16 packet checker port assertions
// Checks result timing and result consistency seen at the core's ports.
// ---------------------------------------------------------------------------
`include "crc16_packet_checker_core_defines.svh"

module crc16pc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                byte_valid,
  input logic                                byte_ready,
  input crc16pc_pkg::byte_req_t              byte_data,
  input logic                                status_valid,
  input logic                                status_ready,
  input crc16pc_pkg::result_t                status_data
);

  `CRC16PC_ASSERT(a_result_holds, status_valid && !status_ready |=> status_valid, "result dropped while stalled")
  `CRC16PC_ASSERT(a_last_gives_result, byte_valid && byte_ready && byte_data.last_byte |=> status_valid, "no result after last byte")
  `CRC16PC_ASSERT(a_ok_length, status_valid && status_data.status_code == crc16pc_pkg::STATUS_OK |-> status_data.packet_length >= crc16pc_pkg::MIN_PACKET_BYTES && status_data.packet_length <= crc16pc_pkg::MAX_COUNT, "ok status with bad length")
  `CRC16PC_ASSERT_ALWAYS(a_status_range, status_valid |-> status_data.status_code <= crc16pc_pkg::STATUS_CRC_MISMATCH, "status code out of range")

endmodule

bind crc16_packet_checker_core crc16pc_checker u_crc16pc_checker (.*);

// File: verif/tb_crc16_packet_checker_core.sv
// ---------------------------------------------------------------------------
// CRC-16 packet checker core testbench
// Sends packets byte by byte, tracks the CRC and header capture in its own
// predictor, compares every status with it or a directed row; a short directed
// table opens the run, then come random packets under several length settings.
// ---------------------------------------------------------------------------
module tb_crc16_packet_checker_core;
  import crc16pc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_B = 2'd3;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_BYTES = 330;
  localparam int DIRECTED_COUNT = 24;

  typedef enum logic [1:0] {
    CHECK_PREDICT,
    CHECK_STATUS,
    CHECK_FULL
  } row_check_t;

  typedef struct packed {
    byte_req_t  req;
    row_check_t check;
    status_t    status;
    result_t    want;
  } dir_row_t;

  localparam result_t NO_RESULT = '0;

  localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{8'hFF, 1'b1}, CHECK_FULL, STATUS_TOO_SHORT,
      '{STATUS_TOO_SHORT, 8'hFF, 8'h00, 16'h0000, 7'd1, 16'hFFFF}},
    '{'{8'h00, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'hFF, 1'b1}, CHECK_FULL, STATUS_TOO_SHORT,
      '{STATUS_TOO_SHORT, 8'h00, 8'hFF, 16'h0000, 7'd2, 16'hFFFF}},
    '{'{8'h02, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h7F, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h80, 1'b1}, CHECK_STATUS, STATUS_TOO_SHORT, NO_RESULT},
    '{'{8'h05, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h01, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h34, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h12, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'hAA, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h55, 1'b1}, CHECK_STATUS, STATUS_UNKNOWN_TYPE, NO_RESULT},
    '{'{8'h00, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h80, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'hFF, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'hFF, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h00, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h01, 1'b1}, CHECK_STATUS, STATUS_BELOW_LENGTH, NO_RESULT},
    '{'{8'h02, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'hFE, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h00, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h80, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'h5A, 1'b0}, CHECK_PREDICT, STATUS_OK, NO_RESULT},
    '{'{8'hA5, 1'b1}, CHECK_STATUS, STATUS_BELOW_LENGTH, NO_RESULT}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   byte_valid = 1'b0;
  logic                   byte_ready;
  byte_req_t              byte_data = '0;
  logic                   status_valid;
  logic                   status_ready = 1'b0;
  result_t                status_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0]     cfg_data = '0;

  logic [COUNT_W-1:0] cfg_len_zero;
  logic [COUNT_W-1:0] cfg_len_two;
  logic [15:0]        pkt_crc;
  logic [COUNT_W-1:0] pkt_count;
  logic [7:0]         pkt_delay [2];
  logic [7:0]         pkt_type;
  logic [7:0]         pkt_seq;
  logic [15:0]        pkt_time;

  result_t expected_status_q [$];
  result_t oldest_status;
  int      mismatch_count = 0;
  bit      quiet_mode = 1'b0;

  crc16_packet_checker_core uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .status_valid (status_valid),
    .status_ready (status_ready),
    .status_data  (status_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                   input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) begin
      if (acc[0]) begin
        acc = {1'b0, acc[15:1]} ^ CRC_POLY;
      end else begin
        acc = {1'b0, acc[15:1]};
      end
    end
    return acc;
  endfunction

  function automatic void clear_packet();
    pkt_crc = CRC_INIT;
    pkt_count = '0;
    pkt_delay[0] = '0;
    pkt_delay[1] = '0;
    pkt_type = '0;
    pkt_seq = '0;
    pkt_time = '0;
  endfunction

  function automatic bit track_byte(input byte_req_t req, output result_t res);
    status_t st;
    case (pkt_count)
      7'd0: pkt_type = req.rx_byte;
      7'd1: pkt_seq = req.rx_byte;
      7'd2: pkt_time[7:0] = req.rx_byte;
      7'd3: pkt_time[15:8] = req.rx_byte;
      default: ;
    endcase
    if (pkt_count >= 7'd2) begin
      pkt_crc = crc16_modbus_byte(pkt_crc, pkt_delay[0]);
    end
    pkt_delay[0] = pkt_delay[1];
    pkt_delay[1] = req.rx_byte;
    if (pkt_count < COUNT_LIMIT) begin
      pkt_count = pkt_count + 1'b1;
    end
    res = NO_RESULT;
    if (!req.last_byte) begin
      return 1'b0;
    end
    if (pkt_count < MIN_PACKET_BYTES) begin
      st = STATUS_TOO_SHORT;
    end else if (pkt_count > MAX_COUNT) begin
      st = STATUS_TOO_LONG;
    end else if (pkt_type != TYPE_ZERO && pkt_type != TYPE_TWO) begin
      st = STATUS_UNKNOWN_TYPE;
    end else if (pkt_count < ((pkt_type == TYPE_ZERO) ? cfg_len_zero : cfg_len_two)) begin
      st = STATUS_BELOW_LENGTH;
    end else if ({pkt_delay[1], pkt_delay[0]} != pkt_crc) begin
      st = STATUS_CRC_MISMATCH;
    end else begin
      st = STATUS_OK;
    end
    res = '{st, pkt_type, pkt_seq, pkt_time, pkt_count, pkt_crc};
    clear_packet();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  task automatic push_byte(input byte_req_t req, output bit done, output result_t res);
    while (!quiet_mode && $urandom_range(0, 99) < 23) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= req;
    do @(posedge clk); while (!byte_ready);
    done = track_byte(req, res);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_EXPECTED_LEN_TYPE_ZERO) begin
      cfg_len_zero = val;
    end else if (idx == CFG_EXPECTED_LEN_TYPE_TWO) begin
      cfg_len_two = val;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_packet(output int sent);
    logic [7:0]  body [$];
    logic [7:0]  ptype;
    logic [15:0] crc;
    int          kind;
    int          len;
    int          lo;
    int          data_len;
    int          flip;
    bit          fill_crc;
    bit          done;
    result_t     res;
    kind = $urandom_range(0, 99);
    ptype = $urandom_range(0, 1) ? TYPE_TWO : TYPE_ZERO;
    if (kind >= 88) begin
      ptype = 8'($urandom);
    end
    lo = (ptype == TYPE_TWO) ? int'(cfg_len_two) : int'(cfg_len_zero);
    if (lo < 6) lo = 6;
    if (lo > MAX_PACKET_BYTES) lo = MAX_PACKET_BYTES;
    fill_crc = 1'b1;
    if (kind < 60) begin
      len = $urandom_range(lo, (lo + 10 > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : lo + 10);
    end else if (kind < 70) begin
      len = $urandom_range(lo, MAX_PACKET_BYTES);
    end else if (kind < 78) begin
      len = $urandom_range(1, 5);
    end else if (kind < 84) begin
      len = $urandom_range(MAX_PACKET_BYTES + 1, MAX_PACKET_BYTES + 8);
    end else if (kind < 86) begin
      len = $urandom_range(MAX_PACKET_BYTES + 9, 150);
    end else begin
      len = $urandom_range(6, 30);
      fill_crc = $urandom_range(0, 1);
    end
    data_len = (fill_crc && len >= 3) ? len - 2 : len;
    body.push_back(ptype);
    while (body.size() < data_len) body.push_back(8'($urandom));
    if (fill_crc && len >= 3) begin
      crc = CRC_INIT;
      foreach (body[i]) crc = crc16_modbus_byte(crc, body[i]);
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
      if ($urandom_range(0, 9) == 0) begin
        flip = $urandom_range(0, len - 1);
        body[flip] = body[flip] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < len; i++) begin
      push_byte('{body[i], i == len - 1}, done, res);
      if (done) expected_status_q.push_back(res);
    end
    sent = len;
  endtask

  task automatic setup_phase(input int phase);
    case (phase)
      1: begin
        write_reg(CFG_EXPECTED_LEN_TYPE_ZERO, 7'd6);
        write_reg(CFG_EXPECTED_LEN_TYPE_TWO, 7'd64);
      end
      2: begin
        write_reg(CFG_EXPECTED_LEN_TYPE_ZERO, 7'd64);
        write_reg(CFG_EXPECTED_LEN_TYPE_TWO, 7'd6);
      end
      3: begin
        write_reg(CFG_EXPECTED_LEN_TYPE_ZERO, 7'($urandom_range(6, 64)));
        write_reg(CFG_EXPECTED_LEN_TYPE_TWO, 7'($urandom_range(6, 64)));
        write_reg(CFG_INDEX_SPARE_A, 7'h7F);
        write_reg(CFG_INDEX_SPARE_B, 7'h00);
      end
      4: begin
        write_reg(CFG_EXPECTED_LEN_TYPE_ZERO, 7'd0);
        write_reg(CFG_EXPECTED_LEN_TYPE_TWO, 7'd127);
      end
      5: begin
        write_reg(CFG_EXPECTED_LEN_TYPE_ZERO, 7'd127);
        write_reg(CFG_EXPECTED_LEN_TYPE_TWO, 7'($urandom_range(0, 127)));
        write_reg(CFG_INDEX_SPARE_B, 7'($urandom));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    status_ready <= quiet_mode || ($urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    if (!rst && status_valid && status_ready) begin
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected status, expected none, actual %p", $time, status_data);
      end else begin
        oldest_status = expected_status_q.pop_front();
        check_field("status_code", oldest_status.status_code, status_data.status_code);
        check_field("packet_type", oldest_status.packet_type, status_data.packet_type);
        check_field("seq_number", oldest_status.seq_number,
                    status_data.seq_number);
        check_field("timestamp", oldest_status.timestamp, status_data.timestamp);
        check_field("packet_length", oldest_status.packet_length,
                    status_data.packet_length);
        check_field("crc_computed", oldest_status.crc_computed, status_data.crc_computed);
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    bit      done;
    result_t res;
    int      sent;
    int      phase_bytes;
    int      packet_index;
    cfg_len_zero = EXPECTED_LEN_ZERO_RESET;
    cfg_len_two = EXPECTED_LEN_TWO_RESET;
    clear_packet();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      push_byte(DIRECTED_ROWS[i].req, done, res);
      if (done) begin
        if (DIRECTED_ROWS[i].check == CHECK_FULL) begin
          res = DIRECTED_ROWS[i].want;
        end else if (DIRECTED_ROWS[i].check == CHECK_STATUS) begin
          res.status_code = DIRECTED_ROWS[i].status;
        end
        expected_status_q.push_back(res);
      end
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      setup_phase(phase);
      quiet_mode = (phase == 2);
      phase_bytes = 0;
      packet_index = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_random_packet(sent);
        phase_bytes += sent;
        packet_index++;
        if (packet_index % 12 == 0) wait_drained();
      end
    end
    quiet_mode = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/crc16pc_pkg.sv
design/crc16_packet_checker_core.sv
design/crc16pc_checker.sv
verif/tb_crc16_packet_checker_core.sv
